[rtl/elev_pkg.sv]
// elev_pkg: shared types, codes and constants of the elevator controller
`default_nettype none

package elev_pkg;

    // car geometry
    localparam int NUM_FLOORS = 3;
    localparam int MASK_W     = 3;
    localparam int FLOOR_W    = 2;
    localparam int TICK_W     = 8;
    localparam int MODE_W     = 3;
    localparam int HEAD_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // reset values of the tick registers
    localparam logic [TICK_W-1:0] OPEN_TICKS_RST  = TICK_W'(10);
    localparam logic [TICK_W-1:0] WAIT_TICKS_RST  = TICK_W'(20);
    localparam logic [TICK_W-1:0] RUN_TICKS_RST   = TICK_W'(20);
    localparam logic [TICK_W-1:0] CLOSE_TICKS_RST = TICK_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TICKS = 2'd3;

    // mode codes as reported on the result
    localparam logic [MODE_W-1:0] CODE_STOP  = 3'd0;
    localparam logic [MODE_W-1:0] CODE_RUN   = 3'd1;
    localparam logic [MODE_W-1:0] CODE_OPEN  = 3'd2;
    localparam logic [MODE_W-1:0] CODE_CLOSE = 3'd3;
    localparam logic [MODE_W-1:0] CODE_WAIT  = 3'd4;

    // one-hot car mode
    typedef enum logic [4:0] {
        MODE_STOP  = 5'b00001,
        MODE_RUN   = 5'b00010,
        MODE_OPEN  = 5'b00100,
        MODE_CLOSE = 5'b01000,
        MODE_WAIT  = 5'b10000
    } t_mode;

    typedef enum logic [HEAD_W-1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        t_mode              mode;
        t_heading           heading;
        logic [TICK_W-1:0]  countdown;
    } t_car_state;

    typedef struct packed {
        logic [TICK_W-1:0] open_ticks;
        logic [TICK_W-1:0] wait_ticks;
        logic [TICK_W-1:0] run_ticks;
        logic [TICK_W-1:0] close_ticks;
    } t_tick_cfg;

    typedef struct packed {
        logic [MASK_W-1:0] car_mask;
        logic [MASK_W-1:0] up_mask;
        logic [MASK_W-1:0] down_mask;
        logic              open_button;
        logic              close_button;
    } t_tick_req;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_RUN:   c = CODE_RUN;
            MODE_OPEN:  c = CODE_OPEN;
            MODE_CLOSE: c = CODE_CLOSE;
            MODE_WAIT:  c = CODE_WAIT;
            default:    c = CODE_STOP;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/elevator_controller_fsm_unit.sv]
// elevator_controller_fsm_unit: tick-driven elevator car controller, top level
// a result is registered and appears in the cycle after its tick request is accepted
// throughput: one tick request per cycle while o_stall is low; the car state registers loop back through elev_step
// input stall rises only while the result register is full and the output is stalled
// reset (synchronous, active low): floor one, stopped, no heading, countdown zero,
// tick registers back to 10/20/20/10, result register empty
`default_nettype none

module elevator_controller_fsm_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [elev_pkg::MASK_W-1:0]      i_car_request_mask,
    input  logic [elev_pkg::MASK_W-1:0]      i_up_request_mask,
    input  logic [elev_pkg::MASK_W-1:0]      i_down_request_mask,
    input  logic                             i_open_button,
    input  logic                             i_close_button,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [elev_pkg::FLOOR_W-1:0]     o_floor_now,
    output logic [elev_pkg::MODE_W-1:0]      o_mode_now,
    output logic [elev_pkg::HEAD_W-1:0]      o_heading,
    output logic                             o_open_taken,
    output logic                             o_close_taken,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [elev_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [elev_pkg::TICK_W-1:0]      i_cfg_data
);
    import elev_pkg::*;

    // tick registers
    t_tick_cfg  r_cfg;

    // car state, updated once per accepted request
    t_car_state r_state;
    t_car_state n_state;

    // result register
    logic               r_out_valid;
    logic [FLOOR_W-1:0] r_floor;
    logic [MODE_W-1:0]  r_mode;
    logic [HEAD_W-1:0]  r_heading;
    logic               r_open_tk;
    logic               r_close_tk;

    t_tick_req req;
    logic      in_take;
    logic      n_open_tk;
    logic      n_close_tk;

    // the result register takes a new value from a valid request whenever it is empty or being drained
    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_ticks  <= OPEN_TICKS_RST;
            r_cfg.wait_ticks  <= WAIT_TICKS_RST;
            r_cfg.run_ticks   <= RUN_TICKS_RST;
            r_cfg.close_ticks <= CLOSE_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OPEN_TICKS:  r_cfg.open_ticks  <= i_cfg_data;
                CFG_WAIT_TICKS:  r_cfg.wait_ticks  <= i_cfg_data;
                CFG_RUN_TICKS:   r_cfg.run_ticks   <= i_cfg_data;
                CFG_CLOSE_TICKS: r_cfg.close_ticks <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // gather the request fields for the transition logic
    assign req.car_mask     = i_car_request_mask;
    assign req.up_mask      = i_up_request_mask;
    assign req.down_mask    = i_down_request_mask;
    assign req.open_button  = i_open_button;
    assign req.close_button = i_close_button;

    elev_step u_step (
        .i_state       (r_state),
        .i_req         (req),
        .i_cfg         (r_cfg),
        .o_state       (n_state),
        .o_open_taken  (n_open_tk),
        .o_close_taken (n_close_tk)
    );

    // car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.floor     <= FLOOR_W'(1);
            r_state.mode      <= MODE_STOP;
            r_state.heading   <= HEAD_NONE;
            r_state.countdown <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, reports the state after the tick
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_floor    <= n_state.floor;
            r_mode     <= mode_code(n_state.mode);
            r_heading  <= n_state.heading;
            r_open_tk  <= n_open_tk;
            r_close_tk <= n_close_tk;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_floor_now   = r_floor;
    assign o_mode_now    = r_mode;
    assign o_heading     = r_heading;
    assign o_open_taken  = r_open_tk;
    assign o_close_taken = r_close_tk;

endmodule

`default_nettype wire

[rtl/elev_step.sv]
// elev_step: transition logic of the car for one tick
`default_nettype none

module elev_step (
    input  elev_pkg::t_car_state i_state,
    input  elev_pkg::t_tick_req  i_req,
    input  elev_pkg::t_tick_cfg  i_cfg,
    output elev_pkg::t_car_state o_state,
    output logic                 o_open_taken,
    output logic                 o_close_taken
);
    import elev_pkg::*;

    localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS);
    localparam logic [FLOOR_W-1:0] BOT_FLOOR = FLOOR_W'(1);

    logic [NUM_FLOORS-1:0] any_req;
    logic [NUM_FLOORS-1:0] car_at;
    logic [NUM_FLOORS-1:0] up_at;
    logic [NUM_FLOORS-1:0] down_at;
    logic                  low_found;
    logic [FLOOR_W-1:0]    low_floor;
    logic [FLOOR_W-1:0]    run_floor;
    t_heading              run_head;
    logic                  run_hit;

    // any request strictly beyond floor fl in direction hd (none reads as down)
    function automatic logic ahead_of(input logic [NUM_FLOORS-1:0] req,
                                      input logic [FLOOR_W-1:0] fl,
                                      input t_heading hd);
        logic hit;
        hit = 1'b0;
        for (int f = 0; f < NUM_FLOORS; f++) begin
            if (req[f]) begin
                if (hd == HEAD_UP) begin
                    if (FLOOR_W'(f + 1) > fl) hit = 1'b1;
                end else begin
                    if (FLOOR_W'(f + 1) < fl) hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // request bits per floor, floors beyond the masks read as empty
    always_comb begin
        for (int f = 0; f < NUM_FLOORS; f++) begin
            if (f < MASK_W) begin
                car_at[f]  = i_req.car_mask[f];
                up_at[f]   = i_req.up_mask[f];
                down_at[f] = i_req.down_mask[f];
            end else begin
                car_at[f]  = 1'b0;
                up_at[f]   = 1'b0;
                down_at[f] = 1'b0;
            end
            any_req[f] = car_at[f] | up_at[f] | down_at[f];
        end
    end

    // lowest requested floor
    always_comb begin
        low_found = 1'b0;
        low_floor = BOT_FLOOR;
        for (int f = NUM_FLOORS - 1; f >= 0; f--) begin
            if (any_req[f]) begin
                low_found = 1'b1;
                low_floor = FLOOR_W'(f + 1);
            end
        end
    end

    // one floor of travel, turning round at the ends
    always_comb begin
        if (i_state.heading == HEAD_UP) begin
            run_floor = (i_state.floor < TOP_FLOOR) ? i_state.floor + 1'b1 : i_state.floor;
        end else begin
            run_floor = (i_state.floor > BOT_FLOOR) ? i_state.floor - 1'b1 : i_state.floor;
        end
        run_head = i_state.heading;
        if (run_floor == BOT_FLOOR) run_head = HEAD_UP;
        if (run_floor == TOP_FLOOR) run_head = HEAD_DOWN;
        run_hit = 1'b0;
        for (int f = 0; f < NUM_FLOORS; f++) begin
            if (FLOOR_W'(f + 1) == run_floor) begin
                run_hit = car_at[f] || (run_head == HEAD_UP && up_at[f]) ||
                          (run_head == HEAD_DOWN && down_at[f]);
            end
        end
    end

    always_comb begin
        o_state       = i_state;
        o_open_taken  = 1'b0;
        o_close_taken = 1'b0;
        if (i_state.countdown == '0) begin
            unique case (i_state.mode)
                MODE_RUN: begin
                    o_state.floor   = run_floor;
                    o_state.heading = run_head;
                    if (run_hit) begin
                        o_state.mode      = MODE_OPEN;
                        o_state.countdown = i_cfg.open_ticks;
                    end else if (ahead_of(any_req, run_floor, run_head)) begin
                        o_state.mode      = MODE_RUN;
                        o_state.countdown = i_cfg.run_ticks;
                    end else begin
                        o_state.mode    = MODE_STOP;
                        o_state.heading = HEAD_NONE;
                    end
                end
                MODE_OPEN: begin
                    o_state.mode      = MODE_WAIT;
                    o_state.countdown = i_cfg.wait_ticks;
                end
                MODE_WAIT: begin
                    o_state.mode      = MODE_CLOSE;
                    o_state.countdown = i_cfg.close_ticks;
                end
                MODE_CLOSE: begin
                    if ((i_state.heading == HEAD_UP || i_state.heading == HEAD_DOWN) &&
                        ahead_of(any_req, i_state.floor, i_state.heading)) begin
                        o_state.mode      = MODE_RUN;
                        o_state.countdown = i_cfg.run_ticks;
                    end else begin
                        o_state.mode    = MODE_STOP;
                        o_state.heading = HEAD_NONE;
                    end
                end
                default: begin
                    o_state.mode = MODE_STOP;
                    if (i_req.open_button) begin
                        o_state.mode      = MODE_OPEN;
                        o_state.countdown = i_cfg.open_ticks;
                        o_open_taken      = 1'b1;
                    end else if (low_found) begin
                        if (low_floor == i_state.floor) begin
                            o_state.mode      = MODE_OPEN;
                            o_state.countdown = i_cfg.open_ticks;
                        end else begin
                            o_state.mode      = MODE_RUN;
                            o_state.countdown = i_cfg.run_ticks;
                            o_state.heading   = (low_floor > i_state.floor) ? HEAD_UP : HEAD_DOWN;
                        end
                    end
                end
            endcase
        end else begin
            o_state.countdown = i_state.countdown - 1'b1;
            if (i_state.mode == MODE_WAIT) begin
                if (i_req.open_button) begin
                    o_state.countdown = i_cfg.wait_ticks;
                    o_open_taken      = 1'b1;
                end else if (i_req.close_button) begin
                    o_state.countdown = '0;
                    o_close_taken     = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/elev_checker.sv]
// elev_checker: port-level checks of the elevator controller, bound to the top level
`default_nettype none

module elev_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic [elev_pkg::FLOOR_W-1:0]     o_floor_now,
    input  logic [elev_pkg::MODE_W-1:0]      o_mode_now,
    input  logic [elev_pkg::HEAD_W-1:0]      o_heading,
    input  logic                             o_open_taken,
    input  logic                             o_close_taken
);
    import elev_pkg::*;

    // a stalled result stays valid and holds its mode and floor
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mode_now) && $stable(o_floor_now))
        else $error("stalled result changed");

    // a running car always has a heading
    a_run_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mode_now == CODE_RUN |-> o_heading != HEAD_NONE)
        else $error("running without heading");

    // a close press is only taken while waiting, and never with an open press
    a_close_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_close_taken |-> o_mode_now == CODE_WAIT && !o_open_taken)
        else $error("close taken outside waiting");

    // a taken open press leaves the doors opening or waiting
    a_open_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_open_taken |-> o_mode_now == CODE_OPEN || o_mode_now == CODE_WAIT)
        else $error("open taken with doors not opening");

    // floor number stays on the building
    a_floor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_floor_now != '0 && o_floor_now <= FLOOR_W'(NUM_FLOORS))
        else $error("floor out of range");

endmodule

bind elevator_controller_fsm_unit elev_checker u_elev_checker (.*);

`default_nettype wire
